[design/ppx_pkg.sv]
`timescale 1ns / 1ps
// ppx_pkg: shared types and constants for the precedence crossover block.
// No dependencies; imported by ppx_cell and permutation_precedence_crossover.
package ppx_pkg;

    localparam int SYM_BITS    = 3;   // bits per symbol
    localparam int FIELD_W     = 24;  // width of a packed parent or child
    localparam int FIELD_SYMS  = 8;   // symbols that fit in a packed field
    localparam int MASK_W      = 8;   // width of the choice mask

    typedef logic [SYM_BITS-1:0] t_sym;

    // Control and partial result carried from cell to cell.
    typedef struct packed {
        logic              valid;
        logic [MASK_W-1:0] mask;
        logic [FIELD_W-1:0] child;
    } t_beat;

endpackage

[design/ppx_cell.sv]
`timescale 1ns / 1ps
// ppx_cell: one link of the crossover chain; fills one child position.
// Depends on ppx_pkg.
module ppx_cell
    import ppx_pkg::*;
#(
    parameter int PERM_LENGTH = 8,
    parameter int POS         = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_beat                  i_beat,
    input  t_sym                   i_sym_a [PERM_LENGTH],
    input  t_sym                   i_sym_b [PERM_LENGTH],
    input  logic [PERM_LENGTH-1:0] i_live_a,
    input  logic [PERM_LENGTH-1:0] i_live_b,
    output t_beat                  o_beat,
    output t_sym                   o_sym_a [PERM_LENGTH],
    output t_sym                   o_sym_b [PERM_LENGTH],
    output logic [PERM_LENGTH-1:0] o_live_a,
    output logic [PERM_LENGTH-1:0] o_live_b
);

    localparam int IDX_W = $clog2(PERM_LENGTH);
    localparam logic [PERM_LENGTH-1:0] ONE = {{(PERM_LENGTH-1){1'b0}}, 1'b1};

    logic [MASK_W-1:0]      w_mask_sh;
    logic                   w_take;
    t_sym                   w_own_sym [PERM_LENGTH];
    t_sym                   w_oth_sym [PERM_LENGTH];
    logic [PERM_LENGTH-1:0] w_own_live;
    logic [PERM_LENGTH-1:0] w_oth_live;
    logic                   w_found;
    logic [IDX_W-1:0]       w_j;
    t_sym                   w_sym;
    logic [PERM_LENGTH-1:0] w_own_next;
    logic [PERM_LENGTH-1:0] w_match;
    logic [PERM_LENGTH-1:0] w_oth_next;
    logic [FIELD_W-1:0]     w_put;

    t_beat                  r_beat, n_beat;
    t_sym                   r_sym_a [PERM_LENGTH];
    t_sym                   r_sym_b [PERM_LENGTH];
    logic [PERM_LENGTH-1:0] r_live_a, n_live_a;
    logic [PERM_LENGTH-1:0] r_live_b, n_live_b;

    // mask bits past the mask width read as zero (second parent)
    assign w_mask_sh = i_beat.mask >> POS;
    assign w_take    = w_mask_sh[0];

    always_comb begin
        for (int k = 0; k < PERM_LENGTH; k++) begin
            w_own_sym[k] = w_take ? i_sym_a[k] : i_sym_b[k];
            w_oth_sym[k] = w_take ? i_sym_b[k] : i_sym_a[k];
        end
        w_own_live = w_take ? i_live_a : i_live_b;
        w_oth_live = w_take ? i_live_b : i_live_a;

        // earliest live entry of the picked parent
        w_found = 1'b0;
        w_j     = '0;
        for (int k = PERM_LENGTH - 1; k >= 0; k--) begin
            if (w_own_live[k]) begin
                w_found = 1'b1;
                w_j     = IDX_W'(k);
            end
        end
        w_sym      = w_found ? w_own_sym[w_j] : '0;
        w_own_next = w_own_live;
        if (w_found) begin
            w_own_next[w_j] = 1'b0;
        end

        // strike the earliest live copy in the other parent
        for (int k = 0; k < PERM_LENGTH; k++) begin
            w_match[k] = w_found && w_oth_live[k] && (w_oth_sym[k] == w_sym);
        end
        w_oth_next = w_oth_live & ~(w_match & (~w_match + ONE));

        n_live_a = w_take ? w_own_next : w_oth_next;
        n_live_b = w_take ? w_oth_next : w_own_next;

        // positions beyond the packed field drop out of the shift
        w_put        = {{(FIELD_W-SYM_BITS){1'b0}}, w_sym} << (POS * SYM_BITS);
        n_beat       = i_beat;
        n_beat.child = i_beat.child | w_put;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else begin
            r_beat.valid <= n_beat.valid;
        end
        r_beat.mask  <= n_beat.mask;
        r_beat.child <= n_beat.child;
        r_sym_a      <= i_sym_a;
        r_sym_b      <= i_sym_b;
        r_live_a     <= n_live_a;
        r_live_b     <= n_live_b;
    end

    assign o_beat   = r_beat;
    assign o_sym_a  = r_sym_a;
    assign o_sym_b  = r_sym_b;
    assign o_live_a = r_live_a;
    assign o_live_b = r_live_b;

endmodule

[design/permutation_precedence_crossover.sv]
`timescale 1ns / 1ps
// permutation_precedence_crossover: top level, a chain of ppx_cell links.
// Depends on ppx_pkg and ppx_cell.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | start / busy       | i_first_parent, i_second_parent,
//           |                    | i_choice_mask
//  result   | o_valid (strobe)   | o_child
//
// One beat is taken every cycle: busy stays low, since every cell hands its
// work on at each clock and nothing ever waits.
// Each cell registers its work; cell k fills child position k.
// Throughput is one child per cycle.
// Reset (i_rst_n low at a clock edge) clears the valid bit of each cell;
// parents, live bits and partial children are not reset.
// The receiver cannot stall; o_valid marks a one-cycle result.
module permutation_precedence_crossover
    import ppx_pkg::*;
#(
    parameter int PERM_LENGTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FIELD_W-1:0] i_first_parent,
    input  logic [FIELD_W-1:0] i_second_parent,
    input  logic [MASK_W-1:0]  i_choice_mask,
    output logic               o_valid,
    output logic [FIELD_W-1:0] o_child
);

    // stage k feeds cell k; stage PERM_LENGTH is the chain output
    t_beat                  w_beat   [PERM_LENGTH+1];
    t_sym                   w_sym_a  [PERM_LENGTH+1][PERM_LENGTH];
    t_sym                   w_sym_b  [PERM_LENGTH+1][PERM_LENGTH];
    logic [PERM_LENGTH-1:0] w_live_a [PERM_LENGTH+1];
    logic [PERM_LENGTH-1:0] w_live_b [PERM_LENGTH+1];

    assign busy = 1'b0;

    // unpack parents; positions past the field read as symbol zero
    for (genvar k = 0; k < PERM_LENGTH; k++) begin : g_unpack
        if (k < FIELD_SYMS) begin : g_in
            assign w_sym_a[0][k] = i_first_parent[k*SYM_BITS +: SYM_BITS];
            assign w_sym_b[0][k] = i_second_parent[k*SYM_BITS +: SYM_BITS];
        end else begin : g_pad
            assign w_sym_a[0][k] = '0;
            assign w_sym_b[0][k] = '0;
        end
    end

    assign w_beat[0].valid = start;
    assign w_beat[0].mask  = i_choice_mask;
    assign w_beat[0].child = '0;
    assign w_live_a[0]     = '1;
    assign w_live_b[0]     = '1;

    for (genvar k = 0; k < PERM_LENGTH; k++) begin : g_chain
        ppx_cell #(
            .PERM_LENGTH (PERM_LENGTH),
            .POS         (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_beat   (w_beat[k]),
            .i_sym_a  (w_sym_a[k]),
            .i_sym_b  (w_sym_b[k]),
            .i_live_a (w_live_a[k]),
            .i_live_b (w_live_b[k]),
            .o_beat   (w_beat[k+1]),
            .o_sym_a  (w_sym_a[k+1]),
            .o_sym_b  (w_sym_b[k+1]),
            .o_live_a (w_live_a[k+1]),
            .o_live_b (w_live_b[k+1])
        );
    end

    assign o_valid = w_beat[PERM_LENGTH].valid;
    assign o_child = w_beat[PERM_LENGTH].child;

    // The first cell always finds a live entry, so it strikes one or two.
    a_first_strike: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_beat[1].valid |->
            (($countones(w_live_a[1]) + $countones(w_live_b[1])) <= 2*PERM_LENGTH-1) &&
            (($countones(w_live_a[1]) + $countones(w_live_b[1])) >= 2*PERM_LENGTH-2))
        else $error("first cell struck a wrong number of entries");

    // Each cell strikes an own entry unless its parent is used up, so by the
    // end at least PERM_LENGTH entries are struck.
    a_end_strike: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            (($countones(w_live_a[PERM_LENGTH]) + $countones(w_live_b[PERM_LENGTH]))
                <= PERM_LENGTH))
        else $error("too few entries struck at end of chain");

    // A result leaves the chain in the cycle after it left the next-to-last cell.
    a_chain_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_beat[PERM_LENGTH-1].valid |=> o_valid)
        else $error("beat lost in the cell chain");

endmodule
